/* rtl/core/srjf_pkg.sv */
// ----------------------------------------------------------------------------
// srjf_pkg: shared types and codes for the task scheduler
// Operation codes, status codes, slot entry layout and result word.
// ----------------------------------------------------------------------------
package srjf_pkg;

	typedef enum logic [1:0] {
		OP_ARRIVE = 2'd0,
		OP_PICK   = 2'd1,
		OP_RUNEND = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_NOTHING = 3'd2;
	localparam logic [2:0] ST_NORUN   = 3'd3;
	localparam logic [2:0] ST_BUSY    = 3'd4;

	localparam logic [7:0] FIRST_QUANTUM_RST = 8'd3;
	localparam logic [7:0] LATER_QUANTUM_RST = 8'd7;

	// one table slot as held in the slot memory
	typedef struct packed {
		logic        shell;
		logic [7:0]  remaining;
		logic [31:0] arrival;
		logic [7:0]  label;
		logic [7:0]  owner;
		logic        first;
	} entry_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        preempt;
		logic [7:0]  picked_label;
		logic        picked_shell;
		logic [7:0]  remaining_time;
		logic [7:0]  slice;
		logic        retired;
		logic        kill_running;
		logic [3:0]  dropped_count;
		logic [15:0] timeline_clock;
	} res_t;

endpackage

/* rtl/core/srjf_round_robin_task_scheduler.sv */
// ----------------------------------------------------------------------------
// srjf_round_robin_task_scheduler: shortest-remaining-first task table
// Arrive, pick, run-end and remove-client words over a slot memory.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  in      | sink      | in_valid/in_ready, opcode .. child_exited
//  out     | source    | out_valid/out_ready, status .. timeline_clock
//  cfg     | sink      | cfg_valid/cfg_ready, cfg_index, cfg_data
//
// Arrive, run-end and busy pick go through the execute and response steps to the output register.
// Pick and remove-client scan the slot memory one slot a cycle through its
// single read port, then drain and select; pick adds a load step for the fetch.
// Reset clears valid bits, counters and the running task; no clearing pass.
// One word is worked at a time; a held output word stalls only the last step.
module srjf_round_robin_task_scheduler #(
	parameter int TASK_SLOTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] task_label,
	input  logic [7:0] client_tag,
	input  logic       is_shell,
	input  logic [7:0] burst,
	input  logic [7:0] elapsed,
	input  logic       child_exited,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic       preempt,
	output logic [7:0] picked_label,
	output logic       picked_shell,
	output logic [7:0] remaining_time,
	output logic [7:0] slice,
	output logic       retired,
	output logic       kill_running,
	output logic [3:0] dropped_count,
	output logic [15:0] timeline_clock,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);
	import srjf_pkg::*;

	localparam int IW = $clog2(TASK_SLOTS);
	localparam int CW = $clog2(TASK_SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(TASK_SLOTS - 1);
	localparam logic [CW:0]   SLOTS_C  = (CW+1)'(TASK_SLOTS);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EXEC  = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_DRAIN = 7'b0001000,
		S_SEL   = 7'b0010000,
		S_LOAD  = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t st_q;

	// latched input word
	op_t        op_q;
	logic [7:0] label_q, tag_q, burst_q, elapsed_q;
	logic       shell_q, exited_q;

	logic [7:0]  fq_q, lq_q;
	logic [TASK_SLOTS-1:0] valid_q;
	logic [CW-1:0] occ_q;
	logic        lr_valid_q;
	logic [IW-1:0] lr_q;
	logic [31:0] ctr_q;
	logic [15:0] clock_q;

	// running task
	logic        run_valid_q, run_shell_q;
	logic [7:0]  run_label_q, run_owner_q, run_rem_q;
	logic [31:0] run_arr_q;

	// scan state
	logic [IW-1:0] idx_q, idx_s1, sel_q;
	logic        p_s1, vld_s1;
	logic        sh_found_q, pb_found_q;
	logic [IW-1:0] sh_idx_q, pb_idx_q, only_q;
	logic [31:0] sh_arr_q, pb_arr_q;
	logic [7:0]  pb_rem_q;
	logic [CW-1:0] pcnt_q, drop_q;

	res_t res_q, out_q, res_d;
	logic out_valid_q;

	// memory port
	logic        mem_we;
	logic [IW-1:0] mem_waddr, mem_raddr;
	entry_t      mem_wdata, rd;
	logic [$bits(entry_t)-1:0] rd_raw;

	srjf_slot_mem #(.DEPTH(TASK_SLOTS), .WIDTH($bits(entry_t))) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd_raw)
	);
	assign rd = entry_t'(rd_raw);

	// lowest free slot
	logic [IW-1:0] free_idx;
	always_comb begin
		free_idx = '0;
		for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_idx = IW'(i);
		end
	end

	logic       full;
	logic [7:0] e_clamp, new_rem;
	logic       requeue;
	assign full    = ({1'b0, occ_q} + (CW+1)'(run_valid_q)) >= SLOTS_C;
	assign e_clamp = (elapsed_q > run_rem_q) ? run_rem_q : elapsed_q;
	assign new_rem = run_rem_q - e_clamp;
	assign requeue = !run_shell_q && !exited_q && (new_rem != 8'd0);

	logic          pick_none;
	logic [IW-1:0] chosen;
	always_comb begin
		pick_none = 1'b0;
		if (sh_found_q) chosen = sh_idx_q;
		else if (pcnt_q == '0) begin
			chosen = '0;
			pick_none = 1'b1;
		end else if (pcnt_q == CW'(1)) chosen = only_q;
		else chosen = pb_idx_q;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = free_idx;
		mem_wdata = '0;
		if (st_q == S_EXEC) begin
			unique case (op_q)
				OP_ARRIVE: begin
					mem_we    = !full;
					mem_wdata = '{shell: shell_q, remaining: shell_q ? 8'd0 : burst_q,
						arrival: ctr_q + 32'd1, label: label_q, owner: tag_q, first: 1'b1};
				end
				OP_RUNEND: begin
					mem_we    = run_valid_q && requeue;
					mem_wdata = '{shell: 1'b0, remaining: new_rem, arrival: run_arr_q,
						label: run_label_q, owner: run_owner_q, first: 1'b0};
				end
				OP_PICK, OP_REMOVE: ;
				default: ;
			endcase
		end
	end

	// result word for the step that ends this cycle
	always_comb begin
		res_d = '0;
		unique case (st_q)
			S_EXEC: begin
				unique case (op_q)
					OP_ARRIVE: begin
						if (full) res_d.status = ST_FULL;
						else res_d.preempt = run_valid_q &&
							(shell_q || (!run_shell_q && burst_q < run_rem_q));
					end
					OP_RUNEND: begin
						if (!run_valid_q) res_d.status = ST_NORUN;
						else if (run_shell_q) begin
							res_d.retired        = 1'b1;
							res_d.timeline_clock = clock_q;
						end else begin
							res_d.timeline_clock = clock_q + 16'(e_clamp);
							res_d.remaining_time = new_rem;
							res_d.retired        = !requeue;
						end
					end
					OP_PICK: res_d.status = ST_BUSY;
					OP_REMOVE: ;
					default: ;
				endcase
			end
			S_SEL: begin
				if (op_q == OP_REMOVE) begin
					res_d.kill_running  = run_valid_q && (run_owner_q == tag_q);
					res_d.dropped_count = 4'(drop_q);
				end else if (pick_none) begin
					res_d.status = ST_NOTHING;
				end
			end
			S_LOAD: begin
				res_d.picked_label   = rd.label;
				res_d.picked_shell   = rd.shell;
				res_d.remaining_time = rd.remaining;
				res_d.slice = rd.shell ? 8'd0 : (rd.first ? fq_q : lq_q);
			end
			default: ;
		endcase
	end

	assign mem_raddr = (st_q == S_SEL) ? chosen : idx_q;
	assign in_ready  = (st_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// scan compare terms
	logic is_lr, pb_better;
	assign is_lr     = lr_valid_q && (idx_s1 == lr_q);
	assign pb_better = !pb_found_q || (rd.remaining < pb_rem_q) ||
		((rd.remaining == pb_rem_q) && (rd.arrival < pb_arr_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			valid_q     <= '0;
			occ_q       <= '0;
			lr_valid_q  <= 1'b0;
			lr_q        <= '0;
			ctr_q       <= '0;
			clock_q     <= '0;
			run_valid_q <= 1'b0;
			fq_q        <= FIRST_QUANTUM_RST;
			lq_q        <= LATER_QUANTUM_RST;
			out_valid_q <= 1'b0;
			p_s1        <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index) lq_q <= cfg_data;
				else fq_q <= cfg_data;
			end
			if (out_valid_q && out_ready && (st_q != S_RESP)) out_valid_q <= 1'b0;

			if (st_q == S_EXEC || st_q == S_SEL || st_q == S_LOAD) res_q <= res_d;

			p_s1   <= (st_q == S_SCAN);
			idx_s1 <= idx_q;
			vld_s1 <= valid_q[idx_q];

			// per-slot scan step on the word read last cycle
			if (p_s1 && vld_s1) begin
				if (op_q == OP_REMOVE) begin
					if (rd.owner == tag_q) begin
						valid_q[idx_s1] <= 1'b0;
						occ_q  <= occ_q - CW'(1);
						drop_q <= drop_q + CW'(1);
						if (is_lr) lr_valid_q <= 1'b0;
					end
				end else if (rd.shell) begin
					if (!sh_found_q || rd.arrival < sh_arr_q) begin
						sh_found_q <= 1'b1;
						sh_idx_q   <= idx_s1;
						sh_arr_q   <= rd.arrival;
					end
				end else begin
					pcnt_q <= pcnt_q + CW'(1);
					only_q <= idx_s1;
					if (!is_lr && pb_better) begin
						pb_found_q <= 1'b1;
						pb_idx_q   <= idx_s1;
						pb_rem_q   <= rd.remaining;
						pb_arr_q   <= rd.arrival;
					end
				end
			end

			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q      <= op_t'(opcode);
						label_q   <= task_label;
						tag_q     <= client_tag;
						shell_q   <= is_shell;
						burst_q   <= burst;
						elapsed_q <= elapsed;
						exited_q  <= child_exited;
						idx_q      <= '0;
						sh_found_q <= 1'b0;
						pb_found_q <= 1'b0;
						pcnt_q     <= '0;
						drop_q     <= '0;
						if ((opcode == OP_REMOVE) || (opcode == OP_PICK && !run_valid_q))
							st_q <= S_SCAN;
						else
							st_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (op_q)
						OP_ARRIVE: begin
							if (!full) begin
								ctr_q  <= ctr_q + 32'd1;
								valid_q[free_idx] <= 1'b1;
								occ_q  <= occ_q + CW'(1);
							end
						end
						OP_RUNEND: begin
							if (run_valid_q) begin
								run_valid_q <= 1'b0;
								if (!run_shell_q) begin
									clock_q <= clock_q + 16'(e_clamp);
									if (requeue) begin
										valid_q[free_idx] <= 1'b1;
										occ_q      <= occ_q + CW'(1);
										lr_valid_q <= 1'b1;
										lr_q       <= free_idx;
									end else begin
										lr_valid_q <= 1'b0;
									end
								end
							end
						end
						OP_PICK: ;
						OP_REMOVE: ;
						default: ;
					endcase
					st_q <= S_RESP;
				end
				S_SCAN: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == LAST_IDX) st_q <= S_DRAIN;
				end
				S_DRAIN: st_q <= S_SEL;
				S_SEL: begin
					sel_q <= chosen;
					if (op_q == OP_REMOVE || pick_none) st_q <= S_RESP;
					else st_q <= S_LOAD;
				end
				S_LOAD: begin
					valid_q[sel_q] <= 1'b0;
					occ_q <= occ_q - CW'(1);
					if (lr_valid_q && lr_q == sel_q) lr_valid_q <= 1'b0;
					run_valid_q <= 1'b1;
					run_label_q <= rd.label;
					run_owner_q <= rd.owner;
					run_shell_q <= rd.shell;
					run_rem_q   <= rd.remaining;
					run_arr_q   <= rd.arrival;
					st_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign preempt        = out_q.preempt;
	assign picked_label   = out_q.picked_label;
	assign picked_shell   = out_q.picked_shell;
	assign remaining_time = out_q.remaining_time;
	assign slice          = out_q.slice;
	assign retired        = out_q.retired;
	assign kill_running   = out_q.kill_running;
	assign dropped_count  = out_q.dropped_count;
	assign timeline_clock = out_q.timeline_clock;

`ifndef SYNTHESIS
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == CW'($countones(valid_q)))
		else $error("occupancy count out of step with valid bits");
	a_occ_limit: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, occ_q} + (CW+1)'(run_valid_q)) <= SLOTS_C)
		else $error("table holds more tasks than slots");
	a_lr_valid: assert property (@(posedge clk) disable iff (!arst_n)
		lr_valid_q |-> valid_q[lr_q])
		else $error("last-run mark on an empty slot");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_LOAD) |-> (!run_valid_q && valid_q[sel_q]))
		else $error("pick loads while a task runs or from an empty slot");
`endif

endmodule

/* rtl/core/srjf_slot_mem.sv */
// ----------------------------------------------------------------------------
// srjf_slot_mem: slot table storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srjf_slot_mem #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 58
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
